/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion shorthands, clocked on clk and quiet while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rss assertion failed");

// expression must never be true at a clock edge out of reset
`define RSS_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("rss forbidden condition seen");

`endif

/* rtl/rss_pkg.sv */
// ---------------------------------------------------------------------------
// rss_pkg
// types and constants shared by the ranked sequence store
// ---------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

	// field widths fixed by the interface
	localparam int RANK_W  = 9;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 9;

	// cells per leaf of the registered read tree
	localparam int GROUP = 16;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_REPLACE = 2'd1,
		KIND_REMOVE  = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_RANK = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// command broadcast along the cell row
	typedef struct packed {
		logic              shift_up;
		logic              shift_down;
		logic              write;
		logic [RANK_W-1:0] rank;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/rss_cell.sv */
// ---------------------------------------------------------------------------
// rss_cell
// one storage cell: holds the element at its own rank, trades with neighbors
// ---------------------------------------------------------------------------
`default_nettype none

module rss_cell #(
	parameter int INDEX      = 0,
	parameter int IDX_W      = 8,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire rss_pkg::cell_cmd_t    cmd,
	input  wire logic [ELEM_WIDTH-1:0] value,
	input  wire logic [ELEM_WIDTH-1:0] left_data,
	input  wire logic [ELEM_WIDTH-1:0] right_data,
	output logic      [ELEM_WIDTH-1:0] data,
	output logic      [ELEM_WIDTH-1:0] sel_data
);

	localparam int CMP_W = (IDX_W > rss_pkg::RANK_W) ? IDX_W : rss_pkg::RANK_W;

	logic [CMP_W-1:0]      idx_c;
	logic [CMP_W-1:0]      rank_c;
	logic                  above;
	logic                  at;
	logic [ELEM_WIDTH-1:0] data_q;

	// position of this cell against the addressed rank
	assign idx_c  = CMP_W'(INDEX);
	assign rank_c = CMP_W'(cmd.rank);
	assign above  = idx_c > rank_c;
	assign at     = idx_c == rank_c;

	// shift up, write, shift down or hold
	always_ff @(posedge clk) begin
		priority if (cmd.shift_up && above) begin
			data_q <= left_data;
		end else if (cmd.write && at) begin
			data_q <= value;
		end else if (cmd.shift_down && (above || at)) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data     = data_q;
	// only the addressed cell drives the read tree
	assign sel_data = at ? data_q : '0;

endmodule

`default_nettype wire

/* rtl/rss_chain.sv */
// ---------------------------------------------------------------------------
// rss_chain
// row of storage cells with a two-level registered read tree
// ---------------------------------------------------------------------------
`default_nettype none

module rss_chain #(
	parameter int CAPACITY   = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire rss_pkg::cell_cmd_t    cmd,
	input  wire logic [ELEM_WIDTH-1:0] value,
	output logic      [ELEM_WIDTH-1:0] rd_data
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NGRP  = (CAPACITY + rss_pkg::GROUP - 1) / rss_pkg::GROUP;

	logic [ELEM_WIDTH-1:0] data     [CAPACITY];
	logic [ELEM_WIDTH-1:0] sel_data [CAPACITY];
	logic [ELEM_WIDTH-1:0] grp_or   [NGRP];
	logic [ELEM_WIDTH-1:0] grp_s2   [NGRP];

	// cells, each wired to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_d;
		logic [ELEM_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = data[i];
		end else begin : g_mid_r
			assign right_d = data[i+1];
		end

		rss_cell #(
			.INDEX      (i),
			.IDX_W      (IDX_W),
			.ELEM_WIDTH (ELEM_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (data[i]),
			.sel_data   (sel_data[i])
		);
	end

	// first tree level: OR each group of cells, then register
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		localparam int LO = g * rss_pkg::GROUP;
		localparam int HI = (LO + rss_pkg::GROUP < CAPACITY) ?
			LO + rss_pkg::GROUP : CAPACITY;

		always_comb begin
			grp_or[g] = '0;
			for (int j = LO; j < HI; j++) begin
				grp_or[g] = grp_or[g] | sel_data[j];
			end
		end

		always_ff @(posedge clk) begin
			grp_s2[g] <= grp_or[g];
		end
	end

	// second tree level: OR the group registers
	always_comb begin
		rd_data = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_data = rd_data | grp_s2[g];
		end
	end

endmodule

`default_nettype wire

/* rtl/ranked_sequence_store_top.sv */
// ---------------------------------------------------------------------------
// ranked_sequence_store_top
// bounded sequence addressed by rank: insert, replace, remove, read
// ---------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Its result is
// on status, value_out, count and is_empty for one cycle with done high, once
// the beat has passed the stage 1, stage 2 and result registers; the receiver
// cannot stall it, so it must take every beat while done is high. A new
// command can be taken before the last one has returned its result: busy is
// high only for the one cycle in which the cell row shifts or writes, and the
// read of the addressed element then finishes in a registered OR tree during
// the cycle in which the next command can already be taken. Every cell
// compares its own index with the rank, so inserts and removes shift all
// later entries in that single cycle. The store needs no clearing after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ranked_sequence_store_top #(
	parameter int CAPACITY   = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    kind,
	input  wire logic [rss_pkg::RANK_W-1:0]    rank,
	input  wire logic [rss_pkg::VALUE_W-1:0]   value_in,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [rss_pkg::VALUE_W-1:0]        value_out,
	output logic [rss_pkg::COUNT_W-1:0]        count,
	output logic                               is_empty
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > rss_pkg::RANK_W) ? CNT_W : rss_pkg::RANK_W;

	logic                         accept;
	rss_pkg::kind_t               kind_c;
	rss_pkg::status_t             status_c;
	logic [CMP_W-1:0]             rank_c;
	logic [CMP_W-1:0]             cnt_c;

	logic                         s1_valid_q;
	rss_pkg::kind_t               kind_s1;
	logic [rss_pkg::RANK_W-1:0]   rank_s1;
	logic [ELEM_WIDTH-1:0]        value_s1;
	rss_pkg::status_t             status_s1;

	logic                         s2_valid_q;
	rss_pkg::kind_t               kind_s2;
	rss_pkg::status_t             status_s2;

	logic [CNT_W-1:0]             count_q;
	logic                         op_ok;
	rss_pkg::cell_cmd_t           cmd;
	logic [ELEM_WIDTH-1:0]        rd_data;

	logic                         done_q;
	rss_pkg::status_t             status_q;
	logic [rss_pkg::VALUE_W-1:0]  value_out_q;
	logic [rss_pkg::COUNT_W-1:0]  count_out_q;
	logic                         is_empty_q;

	assign busy   = s1_valid_q;
	assign accept = start && !busy;
	assign kind_c = rss_pkg::kind_t'(kind);
	assign rank_c = CMP_W'(rank);
	assign cnt_c  = CMP_W'(count_q);

	// rank and capacity checks against the current count
	always_comb begin
		if (kind_c == rss_pkg::KIND_INSERT) begin
			priority if (rank_c > cnt_c) begin
				status_c = rss_pkg::ST_BAD_RANK;
			end else if (cnt_c == CMP_W'(CAPACITY)) begin
				status_c = rss_pkg::ST_FULL;
			end else begin
				status_c = rss_pkg::ST_OK;
			end
		end else if (rank_c >= cnt_c) begin
			status_c = rss_pkg::ST_BAD_RANK;
		end else begin
			status_c = rss_pkg::ST_OK;
		end
	end

	// stage 1 and stage 2 control: one beat in flight through the cell update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			s2_valid_q <= s1_valid_q;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind_c;
			rank_s1   <= rank;
			value_s1  <= ELEM_WIDTH'(value_in);
			status_s1 <= status_c;
		end
	end

	// stage 2 payload, alongside the read tree register
	always_ff @(posedge clk) begin
		kind_s2   <= kind_s1;
		status_s2 <= status_s1;
	end

	// command to the cell row
	assign op_ok          = s1_valid_q && (status_s1 == rss_pkg::ST_OK);
	assign cmd.shift_up   = op_ok && (kind_s1 == rss_pkg::KIND_INSERT);
	assign cmd.shift_down = op_ok && (kind_s1 == rss_pkg::KIND_REMOVE);
	assign cmd.write      = op_ok && ((kind_s1 == rss_pkg::KIND_INSERT) ||
		(kind_s1 == rss_pkg::KIND_REPLACE));
	assign cmd.rank       = rank_s1;

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.shift_up) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.shift_down) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	rss_chain #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.value   (value_s1),
		.rd_data (rd_data)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s2_valid_q;
		end
	end

	// result beat; count_q already holds the post-operation count here
	always_ff @(posedge clk) begin
		if (s2_valid_q) begin
			status_q    <= status_s2;
			count_out_q <= rss_pkg::COUNT_W'(count_q);
			is_empty_q  <= count_q == '0;
			if (status_s2 == rss_pkg::ST_OK && kind_s2 != rss_pkg::KIND_INSERT) begin
				value_out_q <= rss_pkg::VALUE_W'(rd_data);
			end else begin
				value_out_q <= '0;
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;
	assign count     = count_out_q;
	assign is_empty  = is_empty_q;

endmodule

`default_nettype wire

/* rtl/rss_checker.sv */
// ---------------------------------------------------------------------------
// rss_checker
// port-level timing and result checks for the ranked sequence store
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rss_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [31:0] value_out,
	input wire logic [8:0]  count,
	input wire logic        is_empty
);

	// an accepted beat blocks the next edge and returns one result later
	`RSS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
	`RSS_ASSERT(a_accept_done, (start && !busy) |-> ##3 done)
	// a result strobe is never directly followed by another
	`RSS_ASSERT(a_done_spaced, done |=> !done)
	// errors carry no element, and the empty flag follows the count
	`RSS_NEVER(a_err_value, done && status != rss_pkg::ST_OK && value_out != '0)
	`RSS_ASSERT(a_empty_flag, done |-> (is_empty == (count == '0)))

endmodule

bind ranked_sequence_store_top rss_checker u_rss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.value_out (value_out),
	.count     (count),
	.is_empty  (is_empty)
);

`default_nettype wire
